>>> rtl/line_edit_buffer_macros.svh
// Assertion helpers for the line editor RTL.
`ifndef LINE_EDIT_BUFFER_MACROS_SVH
`define LINE_EDIT_BUFFER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LEB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define LEB_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/leb_pkg.sv
`timescale 1ns / 1ps
package leb_pkg;

   localparam int LINE_CAP_DEF = 63;
   localparam int POS_W        = 6;
   localparam int BYTE_W       = 8;

   localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

   typedef enum logic [2:0] {
      CMD_CHAR   = 3'd0,
      CMD_LEFT   = 3'd1,
      CMD_RIGHT  = 3'd2,
      CMD_BACKSP = 3'd3,
      CMD_RETURN = 3'd4,
      CMD_TAB    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef enum logic {
      KIND_EDIT = 1'b0,
      KIND_BYTE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CHAIN_HOLD,
      CHAIN_INSERT,
      CHAIN_DELETE,
      CHAIN_SHIFT_OUT
   } chain_op_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_EMIT
   } fsm_state_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [BYTE_W-1:0] key_byte;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [1:0]        status;
      logic [POS_W-1:0]  cursor_pos;
      logic [POS_W-1:0]  line_len;
      logic [BYTE_W-1:0] line_byte;
      logic              token_start;
      logic              last;
   } rsp_type;

   // Broadcast from the controller to every cell of the row.
   typedef struct packed {
      chain_op_type      op;
      logic [POS_W-1:0]  cursor;
      logic [BYTE_W-1:0] key;
   } chain_ctrl_type;

endpackage

>>> rtl/line_edit_buffer.sv
`timescale 1ns / 1ps
// Keyboard line editor. Each request word carries one key command; the line is held in a
// row of LINE_CAP byte cells, and an insert, tab or backspace moves the affected bytes one
// cell over, all cells at once. Insert, tab, left, right, backspace and unknown commands
// each give one status response word with the new cursor and length. Return gives one
// response word per stored byte, drained from cell 0 while the row shifts toward it, and
// takes no new request until the last byte is out; an empty line gives a single status
// word. A new request is taken once the previous one is fully drained and the response
// register is free or being read in the same cycle.
module line_edit_buffer
   import leb_pkg::*;
#(
   parameter int LINE_CAP = LINE_CAP_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "line_edit_buffer_macros.svh"

   localparam logic [POS_W-1:0] CAP_POS = POS_W'(LINE_CAP);

   fsm_state_type     state_ff, state_in;
   logic [POS_W-1:0]  cursor_ff, cursor_in;
   logic [POS_W-1:0]  length_ff, length_in;
   logic [POS_W-1:0]  emit_cnt_ff, emit_cnt_in;
   logic              prev_sep_ff, prev_sep_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   chain_ctrl_type    ctrl;
   logic              out_free;
   logic              head_sep;
   logic [BYTE_W-1:0] head_byte;
   logic [BYTE_W-1:0] cell_bytes [LINE_CAP];

   // Row of byte cells; neighbors past the ends read as zero.
   for (genvar g = 0; g < LINE_CAP; g++) begin : g_cell
      logic [BYTE_W-1:0] left_w;
      logic [BYTE_W-1:0] right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_bytes[g-1];
      end
      if (g == LINE_CAP - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_bytes[g+1];
      end
      leb_cell #(
         .INDEX(g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_byte  (left_w),
         .right_byte (right_w),
         .cell_byte  (cell_bytes[g])
      );
   end

   assign head_byte = cell_bytes[0];
   // a space or a zero byte separates tokens
   assign head_sep  = (head_byte == SPACE_BYTE) || (head_byte == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      length_in    = length_ff;
      emit_cnt_in  = emit_cnt_ff;
      prev_sep_in  = prev_sep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ctrl.op      = CHAIN_HOLD;
      ctrl.cursor  = cursor_ff;
      ctrl.key     = req_data.key_byte;
      req_ready    = 1'b0;

      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               rsp_in.kind        = KIND_EDIT;
               rsp_in.status      = ST_IGNORED;
               rsp_in.line_byte   = '0;
               rsp_in.token_start = 1'b0;
               rsp_in.last        = 1'b1;
               rsp_valid_in       = 1'b1;
               unique case (req_data.cmd)
                  CMD_CHAR, CMD_TAB: begin
                     if (length_ff >= CAP_POS) begin
                        // drop the key at capacity
                        rsp_in.status = ST_FULL;
                     end else begin
                        ctrl.op = CHAIN_INSERT;
                        if (req_data.cmd == CMD_TAB) begin
                           ctrl.key = SPACE_BYTE;
                        end
                        cursor_in     = cursor_ff + 1'b1;
                        length_in     = length_ff + 1'b1;
                        rsp_in.status = ST_DONE;
                     end
                  end
                  CMD_LEFT: begin
                     if (cursor_ff != '0) begin
                        cursor_in     = cursor_ff - 1'b1;
                        rsp_in.status = ST_DONE;
                     end
                  end
                  CMD_RIGHT: begin
                     if (cursor_ff < length_ff) begin
                        cursor_in     = cursor_ff + 1'b1;
                        rsp_in.status = ST_DONE;
                     end
                  end
                  CMD_BACKSP: begin
                     if (cursor_ff != '0) begin
                        ctrl.op       = CHAIN_DELETE;
                        cursor_in     = cursor_ff - 1'b1;
                        length_in     = length_ff - 1'b1;
                        rsp_in.status = ST_DONE;
                     end
                  end
                  CMD_RETURN: begin
                     cursor_in = '0;
                     length_in = '0;
                     if (length_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        // no word yet: the line drains from cell 0 starting next cycle
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        emit_cnt_in  = length_ff;
                        prev_sep_in  = 1'b1;
                        state_in     = FSM_EMIT;
                     end
                  end
                  default: rsp_in.status = ST_IGNORED;
               endcase
               rsp_in.cursor_pos = cursor_in;
               rsp_in.line_len   = length_in;
            end
         end
         FSM_EMIT: begin
            if (out_free) begin
               // advance the row one cell toward the head and hand out the head byte, a separator as zero
               ctrl.op            = CHAIN_SHIFT_OUT;
               rsp_valid_in       = 1'b1;
               rsp_in.kind        = KIND_BYTE;
               rsp_in.status      = ST_DONE;
               rsp_in.cursor_pos  = '0;
               rsp_in.line_len    = '0;
               rsp_in.line_byte   = head_sep ? '0 : head_byte;
               rsp_in.token_start = !head_sep && prev_sep_ff;
               rsp_in.last        = (emit_cnt_ff == POS_W'(1));
               prev_sep_in        = head_sep;
               emit_cnt_in        = emit_cnt_ff - 1'b1;
               if (emit_cnt_ff == POS_W'(1)) begin
                  state_in = FSM_IDLE;
               end
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         cursor_ff    <= '0;
         length_ff    <= '0;
         emit_cnt_ff  <= '0;
         prev_sep_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         length_ff    <= length_in;
         emit_cnt_ff  <= emit_cnt_in;
         prev_sep_ff  <= prev_sep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LEB_ASSERT(a_cursor_in_line, cursor_ff <= length_ff, "cursor past end of line")
   `LEB_ASSERT(a_length_cap, length_ff <= CAP_POS, "line length above capacity")
   `LEB_ASSERT(a_emit_count, (state_ff != FSM_EMIT) || (emit_cnt_ff != '0),
      "drain with no bytes left")
   `LEB_ASSERT_NEXT(a_emit_clears, (state_ff == FSM_EMIT),
      (cursor_ff == '0) && (length_ff == '0), "line not cleared while draining")

endmodule

>>> rtl/leb_cell.sv
`timescale 1ns / 1ps
module leb_cell
   import leb_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  chain_ctrl_type    ctrl,
   input  logic [BYTE_W-1:0] left_byte,
   input  logic [BYTE_W-1:0] right_byte,
   output logic [BYTE_W-1:0] cell_byte
);

   localparam logic [POS_W-1:0] MY_POS   = POS_W'(INDEX);
   localparam logic [POS_W-1:0] NEXT_POS = POS_W'(INDEX + 1);

   logic [BYTE_W-1:0] cell_byte_ff;
   logic [BYTE_W-1:0] cell_byte_in;

   always_comb begin
      cell_byte_in = cell_byte_ff;
      unique case (ctrl.op)
         CHAIN_INSERT: begin
            // cell at the cursor takes the key, cells past it take the left neighbor
            if (MY_POS == ctrl.cursor) begin
               cell_byte_in = ctrl.key;
            end else if (MY_POS > ctrl.cursor) begin
               cell_byte_in = left_byte;
            end
         end
         CHAIN_DELETE: begin
            // drop the byte before the cursor: cells from there on pull from the right
            if (NEXT_POS >= ctrl.cursor) begin
               cell_byte_in = right_byte;
            end
         end
         CHAIN_SHIFT_OUT: cell_byte_in = right_byte;
         CHAIN_HOLD:      cell_byte_in = cell_byte_ff;
         default:         cell_byte_in = cell_byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      cell_byte_ff <= cell_byte_in;
   end

   assign cell_byte = cell_byte_ff;

endmodule
